/* src/rppo_pkg.sv */
// Shared types and constants for the RGB pixel point-operation unit.
// Used by the front end, queue, back end, division steps and top level.
package rppo_pkg;

  localparam int COMP_W    = 8;
  localparam int NUM_COMP  = 3;
  localparam int PROD_W    = 2 * COMP_W;
  localparam int TDATA_W   = NUM_COMP * COMP_W;
  localparam int CFG_W     = NUM_COMP * COMP_W;
  localparam int CFG_IDX_W = 3;

  // Operation codes
  localparam logic [2:0] OP_BRIGHTEN = 3'd0;
  localparam logic [2:0] OP_DARKEN   = 3'd1;
  localparam logic [2:0] OP_STRETCH  = 3'd2;
  localparam logic [2:0] OP_NEGATIVE = 3'd3;
  localparam logic [2:0] OP_BINARIZE = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CH_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CH_MAX    = 3'd4;

  typedef logic [NUM_COMP-1:0][COMP_W-1:0] comp_vec_t;
  typedef logic [NUM_COMP-1:0][PROD_W-1:0] acc_vec_t;

  typedef struct packed {
    logic [2:0]        op_mode;
    logic [COMP_W-1:0] max_level;
    logic [COMP_W-1:0] bin_threshold;
    comp_vec_t         ch_min;
    comp_vec_t         ch_max;
  } cfg_t;

  // Classified pixel: data holds the finished result, or the clamped offset
  // (p - min) when the pixel still needs the stretch division.
  typedef struct packed {
    logic                is_stretch;
    logic [NUM_COMP-1:0] flat;
    comp_vec_t           den;
    comp_vec_t           data;
  } entry_t;

  // One stage of the back-end pipeline. acc holds {remainder, numerator/quotient}.
  typedef struct packed {
    logic                valid;
    logic                is_stretch;
    logic [NUM_COMP-1:0] flat;
    comp_vec_t           den;
    acc_vec_t            acc;
    comp_vec_t           pass;
  } pipe_t;

endpackage

/* src/rgb_pixel_point_operation_unit.sv */
// Top level of the RGB pixel point-operation unit: config registers and wiring.
// Depends on rppo_pkg, rppo_front, rppo_queue and rppo_back.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  s_tdata: in_comp0, in_comp1, in_comp2
//   m_*       out        m_tvalid/m_tready  m_tdata: out_comp0..2; m_tuser: flat_range_flag
//   cfg_*     in         cfg_we             cfg_addr index, cfg_wdata value
//
// One pixel per clock while the output is not stalled; a result passes through the queue slot,
// the multiply, an eight-stage quotient pipeline and the output register.
// Synchronous active-high reset clears queue, stage valid bits and config to defaults.
// A stalled output holds the whole back end; the queue absorbs input meanwhile.
module rgb_pixel_point_operation_unit import rppo_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TDATA_W-1:0]   s_tdata,   // [7:0] in_comp0, [15:8] in_comp1, [23:16] in_comp2
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,   // [7:0] out_comp0, [15:8] out_comp1, [23:16] out_comp2
  output logic                 m_tuser,   // [0] flat_range_flag
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t   cfg;
  logic   push;
  entry_t push_entry;
  logic   q_pop;
  logic   q_not_empty;
  logic   q_full;
  entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_mode       <= OP_BRIGHTEN;
      cfg.max_level     <= '1;
      cfg.bin_threshold <= COMP_W'(127);
      cfg.ch_min        <= '0;
      cfg.ch_max        <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OP_MODE:   cfg.op_mode       <= cfg_wdata[2:0];
        REG_MAX_LEVEL: cfg.max_level     <= cfg_wdata[COMP_W-1:0];
        REG_BIN_THR:   cfg.bin_threshold <= cfg_wdata[COMP_W-1:0];
        REG_CH_MIN:    cfg.ch_min        <= cfg_wdata;
        REG_CH_MAX:    cfg.ch_max        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rppo_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .cfg        (cfg),
    .queue_full (q_full),
    .push       (push),
    .entry      (push_entry)
  );

  rppo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .full       (q_full),
    .head       (q_head)
  );

  rppo_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .max_level   (cfg.max_level),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

/* src/rppo_front.sv */
// Front end: accepts pixels and classifies them by operation mode.
// Depends on rppo_pkg; writes classified entries into rppo_queue.
module rppo_front import rppo_pkg::*; (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,
  input  cfg_t               cfg,
  input  logic               queue_full,
  output logic               push,
  output entry_t             entry
);

  comp_vec_t pix;
  logic      up_ok;
  logic      dn_ok;

  assign pix      = s_tdata;
  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    up_ok = 1'b1;
    dn_ok = 1'b1;
    for (int i = 0; i < NUM_COMP; i++) begin
      if (pix[i] >= cfg.max_level) up_ok = 1'b0;
      if (pix[i] == '0) dn_ok = 1'b0;
    end
  end

  always_comb begin
    entry      = '0;
    entry.data = pix;
    case (cfg.op_mode)
      OP_BRIGHTEN: begin
        if (up_ok) begin
          for (int i = 0; i < NUM_COMP; i++) entry.data[i] = pix[i] + COMP_W'(1);
        end
      end
      OP_DARKEN: begin
        if (dn_ok) begin
          for (int i = 0; i < NUM_COMP; i++) entry.data[i] = pix[i] - COMP_W'(1);
        end
      end
      OP_STRETCH: begin
        entry.is_stretch = 1'b1;
        for (int i = 0; i < NUM_COMP; i++) begin
          entry.flat[i] = (cfg.ch_max[i] <= cfg.ch_min[i]);
          entry.den[i]  = cfg.ch_max[i] - cfg.ch_min[i];
          // clamp to [min,max], then take the offset from min
          if (pix[i] < cfg.ch_min[i]) entry.data[i] = '0;
          else if (pix[i] > cfg.ch_max[i]) entry.data[i] = cfg.ch_max[i] - cfg.ch_min[i];
          else entry.data[i] = pix[i] - cfg.ch_min[i];
        end
      end
      OP_NEGATIVE: begin
        for (int i = 0; i < NUM_COMP; i++) begin
          entry.data[i] = (pix[i] > cfg.max_level) ? '0 : cfg.max_level - pix[i];
        end
      end
      OP_BINARIZE: begin
        for (int i = 0; i < NUM_COMP; i++) begin
          entry.data[i] = (pix[0] > cfg.bin_threshold) ? COMP_W'(1) : '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/rppo_queue.sv */
// Short register queue between the front end and the back end.
// Depends on rppo_pkg for the entry type.
module rppo_queue import rppo_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   not_empty,
  output logic   full,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign head      = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop) rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

/* src/rppo_div_step.sv */
// One restoring-division stage: produces one quotient bit per lane.
// Depends on rppo_pkg; chained by rppo_back.
module rppo_div_step import rppo_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  pipe_t stage_in,
  output pipe_t stage_out
);

  pipe_t stage_next;

  always_comb begin
    logic [COMP_W:0] trial;
    logic [COMP_W:0] diff;
    logic            ge;
    stage_next = stage_in;
    for (int i = 0; i < NUM_COMP; i++) begin
      trial = stage_in.acc[i][PROD_W-1:COMP_W-1];
      diff  = trial - {1'b0, stage_in.den[i]};
      ge    = (trial >= {1'b0, stage_in.den[i]});
      // shift the quotient bit in at the bottom, keep the partial remainder on top
      stage_next.acc[i] = {(ge ? diff[COMP_W-1:0] : trial[COMP_W-1:0]),
                           stage_in.acc[i][COMP_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out <= stage_next;
    end
  end

endmodule

/* src/rppo_back.sv */
// Back end: multiply, eight division stages and the output register.
// Depends on rppo_pkg and rppo_div_step; drains rppo_queue.
module rppo_back import rppo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  entry_t             q_head,
  output logic               q_pop,
  input  logic [COMP_W-1:0]  max_level,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser
);

  pipe_t             stg [COMP_W+1];
  logic              advance;
  logic              out_valid;
  comp_vec_t         out_comp;
  logic              out_flag;
  comp_vec_t         fin_comp;

  // the whole pipeline moves together whenever the output slot can take a transfer
  assign advance  = !out_valid || m_tready;
  assign q_pop    = advance && q_not_empty;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_comp;
  assign m_tuser  = out_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else if (advance) begin
      stg[0].valid      <= q_not_empty;
      stg[0].is_stretch <= q_head.is_stretch;
      stg[0].flat       <= q_head.flat;
      stg[0].den        <= q_head.den;
      stg[0].pass       <= q_head.data;
      for (int i = 0; i < NUM_COMP; i++) begin
        stg[0].acc[i] <= PROD_W'(q_head.data[i]) * PROD_W'(max_level);
      end
    end
  end

  for (genvar k = 0; k < COMP_W; k++) begin : g_div
    rppo_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .stage_in  (stg[k]),
      .stage_out (stg[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      if (stg[COMP_W].flat[i]) fin_comp[i] = '0;
      else if (stg[COMP_W].is_stretch) fin_comp[i] = stg[COMP_W].acc[i][COMP_W-1:0];
      else fin_comp[i] = stg[COMP_W].pass[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stg[COMP_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_comp <= fin_comp;
      out_flag <= stg[COMP_W].is_stretch && (|stg[COMP_W].flat);
    end
  end

endmodule

/* dv/rgb_pixel_point_operation_unit_tb.sv */
// Self-checking testbench for rgb_pixel_point_operation_unit: directed and random pixels,
// random handshake gaps on both streams, results checked against an in-bench predictor.
// Depends on rppo_pkg and the RTL under src/.
module rgb_pixel_point_operation_unit_tb;
  import rppo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1150;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    comp_vec_t px;
    logic      flat;
  } pixel_result_t;

  class pixel_scoreboard;
    logic [2:0]        op_mode;
    logic [COMP_W-1:0] max_level;
    logic [COMP_W-1:0] bin_threshold;
    comp_vec_t         ch_min;
    comp_vec_t         ch_max;
    pixel_result_t     expected_pixels[$];
    int                errors;

    function new();
      op_mode       = OP_BRIGHTEN;
      max_level     = 8'd255;
      bin_threshold = 8'd127;
      ch_min        = '0;
      ch_max        = '1;
      errors        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_OP_MODE:   op_mode = val[2:0];
        REG_MAX_LEVEL: max_level = val[COMP_W-1:0];
        REG_BIN_THR:   bin_threshold = val[COMP_W-1:0];
        REG_CH_MIN:    ch_min = val;
        REG_CH_MAX:    ch_max = val;
        default: ;
      endcase
    endfunction

    function pixel_result_t apply_point_op(comp_vec_t px);
      pixel_result_t res;
      bit ok;
      int v, lo, hi, ml;
      ml = max_level;
      res.px = px;
      res.flat = 1'b0;
      case (op_mode)
        OP_BRIGHTEN: begin
          ok = 1;
          for (int i = 0; i < NUM_COMP; i++)
            if (int'(px[i]) + 1 > ml) ok = 0;
          if (ok)
            for (int i = 0; i < NUM_COMP; i++) res.px[i] = px[i] + 8'd1;
        end
        OP_DARKEN: begin
          ok = 1;
          for (int i = 0; i < NUM_COMP; i++)
            if (px[i] == 0) ok = 0;
          if (ok)
            for (int i = 0; i < NUM_COMP; i++) res.px[i] = px[i] - 8'd1;
        end
        OP_STRETCH: begin
          for (int i = 0; i < NUM_COMP; i++) begin
            lo = ch_min[i];
            hi = ch_max[i];
            v  = px[i];
            if (hi <= lo) begin
              // flat or inverted range: zero this channel and raise the flag
              res.px[i] = '0;
              res.flat = 1'b1;
            end else begin
              if (v < lo) v = lo;
              if (v > hi) v = hi;
              res.px[i] = COMP_W'(((v - lo) * ml) / (hi - lo));
            end
          end
        end
        OP_NEGATIVE: begin
          for (int i = 0; i < NUM_COMP; i++)
            res.px[i] = (int'(px[i]) > ml) ? '0 : COMP_W'(ml - int'(px[i]));
        end
        OP_BINARIZE: begin
          for (int i = 0; i < NUM_COMP; i++)
            res.px[i] = (px[0] > bin_threshold) ? 8'd1 : 8'd0;
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_input(comp_vec_t px);
      expected_pixels.push_back(apply_point_op(px));
    endfunction

    function void check_result(comp_vec_t got_px, logic got_flat);
      pixel_result_t exp_res;
      bit bad;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: unexpected result %0d,%0d,%0d flag %0b",
                   got_px[0], got_px[1], got_px[2], got_flat);
        return;
      end
      exp_res = expected_pixels.pop_front();
      bad = 0;
      for (int i = 0; i < NUM_COMP; i++)
        if (got_px[i] !== exp_res.px[i]) bad = 1;
      if (got_flat !== exp_res.flat) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: op %0d expected %0d,%0d,%0d flag %0b, got %0d,%0d,%0d flag %0b",
                   op_mode, exp_res.px[0], exp_res.px[1], exp_res.px[2], exp_res.flat,
                   got_px[0], got_px[1], got_px[2], got_flat);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [TDATA_W-1:0]   m_tdata;
  logic                 m_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  pixel_scoreboard sb;
  bit send_burst;
  int cycles;

  rgb_pixel_point_operation_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic comp_vec_t mk_pixel(int c0, int c1, int c2);
    comp_vec_t px;
    px[0] = c0[COMP_W-1:0];
    px[1] = c1[COMP_W-1:0];
    px[2] = c2[COMP_W-1:0];
    return px;
  endfunction

  // Bias components toward the active range and its edges.
  function automatic comp_vec_t rand_pixel();
    comp_vec_t px;
    int sel, ml;
    ml = sb.max_level;
    for (int i = 0; i < NUM_COMP; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3, 4: px[i] = COMP_W'($urandom_range(0, ml));
        5, 6:          px[i] = COMP_W'($urandom_range(0, 255));
        7: begin
          case ($urandom_range(0, 5))
            0: px[i] = 8'd0;
            1: px[i] = 8'd1;
            2: px[i] = COMP_W'(ml - 1);
            3: px[i] = COMP_W'(ml);
            4: px[i] = COMP_W'(ml + 1);
            default: px[i] = 8'd255;
          endcase
        end
        default: px[i] = COMP_W'($urandom_range(int'(sb.ch_min[i]), int'(sb.ch_max[i])));
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(comp_vec_t px);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    sb.note_input(px);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_all(logic [2:0] op, int ml, int thr,
                         logic [CFG_W-1:0] mn, logic [CFG_W-1:0] mx);
    write_reg(REG_OP_MODE, CFG_W'(op));
    write_reg(REG_MAX_LEVEL, CFG_W'(ml));
    write_reg(REG_BIN_THR, CFG_W'(thr));
    write_reg(REG_CH_MIN, mn);
    write_reg(REG_CH_MAX, mx);
    cfg_we <= 1'b0;
  endtask

  task automatic end_phase();
    s_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random stall before each transfer, with stall-free stretches.
  initial begin
    int stall;
    int left;
    bit burst;
    m_tready = 1'b0;
    burst = 0;
    left = $urandom_range(20, 60);
    wait (rst === 1'b0);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
      if (--left == 0) begin
        burst = ($urandom_range(0, 3) == 0);
        left = $urandom_range(20, 60);
      end
    end
  end

  initial begin
    int sent, n, ml, thr, lo, hi;
    logic [2:0] op;
    comp_vec_t mn, mx;
    sb = new();
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    send_burst = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: brighten at full range, overflow holds the pixel
    send_pixel(mk_pixel(0, 0, 0));
    send_pixel(mk_pixel(254, 254, 254));
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(10, 255, 3));
    end_phase();

    // Binarize against the reset threshold
    write_reg(REG_OP_MODE, CFG_W'(OP_BINARIZE));
    cfg_we <= 1'b0;
    send_pixel(mk_pixel(127, 0, 0));
    send_pixel(mk_pixel(128, 0, 0));
    send_pixel(mk_pixel(0, 255, 255));
    send_pixel(mk_pixel(255, 255, 255));
    end_phase();

    // Stretch over the reset range is the identity
    write_reg(REG_OP_MODE, CFG_W'(OP_STRETCH));
    cfg_we <= 1'b0;
    send_pixel(mk_pixel(0, 128, 255));
    end_phase();

    // Darken: any zero component holds the pixel
    set_all(OP_DARKEN, 200, 127, 24'h000000, 24'hFFFFFF);
    send_pixel(mk_pixel(0, 5, 5));
    send_pixel(mk_pixel(1, 1, 1));
    send_pixel(mk_pixel(255, 128, 7));
    end_phase();

    // Stretch with clamping, one flat and one inverted channel
    set_all(OP_STRETCH, 255, 127, 24'h1E140A, 24'h0514C8);
    send_pixel(mk_pixel(5, 20, 255));
    send_pixel(mk_pixel(250, 0, 0));
    send_pixel(mk_pixel(100, 100, 100));
    end_phase();

    // Negative, components above max_level saturate to zero
    set_all(OP_NEGATIVE, 100, 0, 24'h000000, 24'hFFFFFF);
    send_pixel(mk_pixel(101, 100, 0));
    send_pixel(mk_pixel(255, 50, 1));
    end_phase();

    // Brighten at the smallest range, input above max_level
    set_all(OP_BRIGHTEN, 1, 255, 24'h000000, 24'hFFFFFF);
    send_pixel(mk_pixel(0, 0, 0));
    send_pixel(mk_pixel(1, 0, 0));
    send_pixel(mk_pixel(200, 0, 0));
    end_phase();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      op = 3'($urandom_range(0, 4));
      case ($urandom_range(0, 3))
        0: ml = 255;
        1: ml = 1;
        default: ml = $urandom_range(1, 255);
      endcase
      case ($urandom_range(0, 3))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(0, 255);
      endcase
      for (int i = 0; i < NUM_COMP; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          lo = $urandom_range(0, 254);
          hi = $urandom_range(lo + 1, 255);
        end else begin
          lo = $urandom_range(0, 255);
          hi = $urandom_range(0, 255);
        end
        mn[i] = COMP_W'(lo);
        mx[i] = COMP_W'(hi);
      end
      if ($urandom_range(0, 9) == 0) begin
        mn = '0;
        mx = '1;
      end
      set_all(op, ml, thr, mn, mx);
      send_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      repeat (n) begin
        send_pixel(rand_pixel());
        sent++;
      end
      end_phase();
    end

    if (sb.errors == 0 && sb.expected_pixels.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
